>>> hdl/mi4_pkg.sv
package mi4_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_WRITE,
    S_DIV_RD,
    S_DIV_INIT,
    S_DIV_STEP,
    S_EMIT
  } state_t;

  // Arithmetic phases of one inversion
  typedef enum logic [1:0] {
    PH_MINOR,
    PH_COF,
    PH_DET
  } phase_t;

  // Source of the wide multiplier operand
  typedef enum logic [1:0] {
    SRC_ELEM,
    SRC_MINOR,
    SRC_ADJ
  } bsrc_t;

  localparam logic [3:0] LAST_IDX       = 4'd15;
  localparam logic [3:0] LAST_MINOR     = 4'd11;
  localparam logic [3:0] LAST_COF       = 4'd15;
  localparam logic [1:0] LAST_TERM_MIN  = 2'd1;
  localparam logic [1:0] LAST_TERM_COF  = 2'd2;
  localparam logic [1:0] LAST_TERM_DET  = 2'd3;
  localparam logic [2:0] LAST_DIGIT_CNT = 3'd5;

  // One multiply-accumulate term, decoded from the sequencer position
  typedef struct packed {
    logic [3:0] a_idx;
    bsrc_t      b_src;
    logic [3:0] b_idx;
    logic       neg;
    logic [3:0] dest;
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_we;
    logic [3:0] load_addr;
    phase_t     phase;
    logic [3:0] group;
    logic [1:0] term;
    logic       acc_clr;
    logic       mul_en;
    logic [1:0] digit;
    logic       acc_en;
    logic       wr_en;
    logic       div_sel;
    logic [3:0] elem_idx;
    logic       div_init;
    logic       div_step;
    logic       emit;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic singular;
  } ctl_status_t;

  // Index of a column pair: (0,1)=0 (0,2)=1 (0,3)=2 (1,2)=3 (1,3)=4 (2,3)=5
  function automatic logic [2:0] pair_index(logic [1:0] x, logic [1:0] y);
    logic [3:0] mask;
    mask = (4'b0001 << x) | (4'b0001 << y);
    case (mask)
      4'b0011: return 3'd0;
      4'b0101: return 3'd1;
      4'b1001: return 3'd2;
      4'b0110: return 3'd3;
      4'b1010: return 3'd4;
      4'b1100: return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [1:0] pair_lo(logic [2:0] p);
    case (p)
      3'd0, 3'd1, 3'd2: return 2'd0;
      3'd3, 3'd4:       return 2'd1;
      3'd5:             return 2'd2;
      default:          return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] pair_hi(logic [2:0] p);
    case (p)
      3'd0:       return 2'd1;
      3'd1, 3'd3: return 2'd2;
      3'd2, 3'd4: return 2'd3;
      3'd5:       return 2'd3;
      default:    return 2'd1;
    endcase
  endfunction

  // Operand and destination selection for each term.
  // Minors 0..5: 2x2 of rows 0,1; minors 6..11: 2x2 of rows 2,3.
  // Cofactor (i,j) expands along row i^1 against the minors of the other row pair.
  function automatic op_t decode_op(phase_t ph, logic [3:0] grp, logic [1:0] trm);
    op_t        op;
    logic [2:0] p;
    logic [1:0] rb;
    logic [1:0] j;
    logic [1:0] k;
    logic [1:0] ci;
    logic [1:0] cj;
    logic [1:0] cn;
    op.a_idx = 4'd0;
    op.b_src = SRC_ELEM;
    op.b_idx = 4'd0;
    op.neg   = 1'b0;
    op.dest  = 4'd0;
    case (ph)
      PH_MINOR: begin
        if (grp >= 4'd6) begin
          p  = 3'(grp - 4'd6);
          rb = 2'd2;
        end else begin
          p  = grp[2:0];
          rb = 2'd0;
        end
        j = pair_lo(p);
        k = pair_hi(p);
        if (trm == 2'd0) begin
          op.a_idx = {rb, j};
          op.b_idx = {rb[1], 1'b1, k};
          op.neg   = 1'b0;
        end else begin
          op.a_idx = {rb, k};
          op.b_idx = {rb[1], 1'b1, j};
          op.neg   = 1'b1;
        end
        op.b_src = SRC_ELEM;
        op.dest  = grp;
      end
      PH_COF: begin
        ci = grp[3:2];
        cj = grp[1:0];
        cn = (trm >= cj) ? 2'(trm + 2'd1) : trm;
        op.a_idx = {ci[1], ~ci[0], cn};
        op.b_src = SRC_MINOR;
        op.b_idx = (ci[1] ? 4'd0 : 4'd6) + {1'b0, 3'(3'd5 - pair_index(cj, cn))};
        op.neg   = ci[0] ^ cj[0] ^ (trm == 2'd1);
        op.dest  = {cj, ci};
      end
      default: begin
        op.a_idx = {2'b00, trm};
        op.b_src = SRC_ADJ;
        op.b_idx = {trm, 2'b00};
        op.neg   = 1'b0;
        op.dest  = 4'd0;
      end
    endcase
    return op;
  endfunction

endpackage

>>> hdl/matrix_inverse_4x4_top.sv
// 4x4 fixed-point matrix inverse by cofactors and adjugate.
// Input: pulse start with element_value while busy is low; each such edge is
// one transaction. Elements arrive in flat index order 0..15, one per cycle
// at most. After the sixteenth, busy rises and the block computes twelve 2x2
// minors, sixteen cofactors and the determinant exactly on one shared
// multiplier (element by one digit of a wide operand, four digits per term).
// Each result then comes from a restoring divider, one quotient bit per cycle;
// when the determinant is zero the division steps are skipped. Results appear
// with done high for one cycle each, result_index 0..15, last_of_run on index
// 15; a singular matrix is echoed with singular set. The receiver cannot stall;
// results are not held. busy falls with the last result transaction and a
// new run may load at once. Synchronous reset returns to idle with the load
// count cleared.
module matrix_inverse_4x4_top #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value,
  output logic                            done,
  output logic signed [ELEMENT_WIDTH-1:0] result_value,
  output logic [3:0]                      result_index,
  output logic                            singular,
  output logic                            last_of_run
);
  import mi4_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  mi4_ctrl #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .status(status)
  );

  mi4_datapath #(.ELEMENT_WIDTH(ELEMENT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .element_value(element_value), .done(done), .result_value(result_value),
    .result_index(result_index), .singular(singular), .last_of_run(last_of_run)
  );

endmodule

>>> hdl/mi4_ram.sv
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/mi4_ctrl.sv
module mi4_ctrl #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output mi4_pkg::ctl_cmd_t    cmd,
  input  mi4_pkg::ctl_status_t status
);
  import mi4_pkg::*;

  localparam int IW = $clog2(ELEMENT_WIDTH + 1);

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [3:0] group, group_next;
  logic [1:0] term, term_next;
  logic [2:0] dcnt, dcnt_next;
  logic [3:0] k, k_next;
  logic [IW-1:0] it, it_next;
  logic [3:0] load_count, load_count_next;
  logic [3:0] last_group;
  logic [1:0] last_term;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_MINOR;
      group      <= '0;
      term       <= '0;
      dcnt       <= '0;
      k          <= '0;
      it         <= '0;
      load_count <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      group      <= group_next;
      term       <= term_next;
      dcnt       <= dcnt_next;
      k          <= k_next;
      it         <= it_next;
      load_count <= load_count_next;
    end
  end

  // Group and term bounds per phase
  always_comb begin
    case (phase)
      PH_MINOR: begin
        last_group = LAST_MINOR;
        last_term  = LAST_TERM_MIN;
      end
      PH_COF: begin
        last_group = LAST_COF;
        last_term  = LAST_TERM_COF;
      end
      default: begin
        last_group = 4'd0;
        last_term  = LAST_TERM_DET;
      end
    endcase
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    group_next      = group;
    term_next       = term;
    dcnt_next       = dcnt;
    k_next          = k;
    it_next         = it;
    load_count_next = load_count;

    cmd           = '0;
    cmd.load_addr = load_count;
    cmd.phase     = phase;
    cmd.group     = group;
    cmd.term      = term;
    cmd.digit     = 2'(dcnt - 3'd1);
    cmd.elem_idx  = k;

    busy = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_we     = 1'b1;
          load_count_next = 4'(load_count + 4'd1);
          if (load_count == LAST_IDX) begin
            state_next = S_MAC;
            phase_next = PH_MINOR;
            group_next = '0;
            term_next  = '0;
            dcnt_next  = '0;
          end
        end
      end
      S_MAC: begin
        cmd.acc_clr = (dcnt == 3'd0) && (term == 2'd0);
        cmd.mul_en  = (dcnt >= 3'd1) && (dcnt <= 3'd4);
        cmd.acc_en  = (dcnt >= 3'd2);
        if (dcnt == LAST_DIGIT_CNT) begin
          dcnt_next = '0;
          if (term == last_term) begin
            state_next = S_WRITE;
          end else begin
            term_next = 2'(term + 2'd1);
          end
        end else begin
          dcnt_next = 3'(dcnt + 3'd1);
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        term_next = '0;
        if (group == last_group) begin
          group_next = '0;
          case (phase)
            PH_MINOR: begin
              phase_next = PH_COF;
              state_next = S_MAC;
            end
            PH_COF: begin
              phase_next = PH_DET;
              state_next = S_MAC;
            end
            default: begin
              k_next     = '0;
              state_next = S_DIV_RD;
            end
          endcase
        end else begin
          group_next = 4'(group + 4'd1);
          state_next = S_MAC;
        end
      end
      S_DIV_RD: begin
        cmd.div_sel = 1'b1;
        state_next  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_sel  = 1'b1;
        cmd.div_init = 1'b1;
        it_next      = '0;
        state_next   = status.singular ? S_EMIT : S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_sel  = 1'b1;
        cmd.div_step = 1'b1;
        it_next      = IW'(it + 1'b1);
        if (it == IW'(ELEMENT_WIDTH)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.div_sel = 1'b1;
        cmd.emit    = 1'b1;
        if (k == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          k_next     = 4'(k + 4'd1);
          state_next = S_DIV_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A zero determinant never enters the divider
  a_no_div_singular: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_STEP) |-> !status.singular)
    else $error("divider running on singular matrix");

  // The sixteenth result ends the run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && k == LAST_IDX) |=> (state == S_IDLE))
    else $error("run did not end after last result");

  // Loading happens only in idle, so the store is stable during compute
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_we |-> (state == S_IDLE && !busy))
    else $error("element load outside idle");

endmodule

>>> hdl/mi4_datapath.sv
module mi4_datapath #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRAC_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mi4_pkg::ctl_cmd_t               cmd,
  output mi4_pkg::ctl_status_t            status,
  input  logic signed [ELEMENT_WIDTH-1:0] element_value,
  output logic                            done,
  output logic signed [ELEMENT_WIDTH-1:0] result_value,
  output logic [3:0]                      result_index,
  output logic                            singular,
  output logic                            last_of_run
);
  import mi4_pkg::*;

  localparam int EW   = ELEMENT_WIDTH;
  localparam int MW   = 2 * EW + 1;
  localparam int AW   = 3 * EW + 1;
  localparam int BW   = 4 * EW;
  localparam int ACCW = 4 * EW + 2;
  localparam int PW   = 2 * EW + 1;
  localparam int NW   = 3 * EW + 2 * FRAC_BITS;
  localparam int DW   = 5 * EW + 1;
  localparam int CW   = (NW > DW) ? NW : DW;
  localparam int QW   = EW + 1;
  localparam logic [QW-1:0] HALF     = QW'(1) << (EW - 1);
  localparam logic [QW-1:0] HALF_M1  = HALF - QW'(1);

  op_t op;
  logic [3:0] elem_a_addr, adj_addr;
  logic [EW-1:0] elem_a, elem_b;
  logic [MW-1:0] minor_rd;
  logic [AW-1:0] adj_rd;
  logic [BW-1:0] b_ext;
  logic signed [EW:0] dig;
  logic signed [PW-1:0] prod;
  logic [1:0] prod_digit;
  logic prod_neg;
  logic [ACCW-1:0] acc, term_ext, term_sh;
  logic [ACCW-1:0] det, det_mag;
  logic [AW-1:0] adj_mag;
  logic [NW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] q, q_sat;
  logic qneg;
  logic ge;
  logic sing;
  logic [EW-1:0] quot_val;

  assign op = decode_op(cmd.phase, cmd.group, cmd.term);
  assign elem_a_addr = cmd.div_sel ? cmd.elem_idx : op.a_idx;
  assign adj_addr    = cmd.div_sel ? cmd.elem_idx : op.b_idx;

  // Element store, two copies for two reads per cycle
  mi4_ram #(.WIDTH(EW), .DEPTH(16)) u_elem_a (
    .clk(clk), .we(cmd.load_we), .waddr(cmd.load_addr), .wdata(element_value),
    .raddr(elem_a_addr), .rdata(elem_a)
  );
  mi4_ram #(.WIDTH(EW), .DEPTH(16)) u_elem_b (
    .clk(clk), .we(cmd.load_we), .waddr(cmd.load_addr), .wdata(element_value),
    .raddr(op.b_idx), .rdata(elem_b)
  );

  // 2x2 minors of row pairs
  mi4_ram #(.WIDTH(MW), .DEPTH(16)) u_minor (
    .clk(clk), .we(cmd.wr_en && cmd.phase == PH_MINOR), .waddr(op.dest),
    .wdata(acc[MW-1:0]), .raddr(op.b_idx), .rdata(minor_rd)
  );

  // Adjugate entries
  mi4_ram #(.WIDTH(AW), .DEPTH(16)) u_adj (
    .clk(clk), .we(cmd.wr_en && cmd.phase == PH_COF), .waddr(op.dest),
    .wdata(acc[AW-1:0]), .raddr(adj_addr), .rdata(adj_rd)
  );

  // Wide operand, sign extended
  always_comb begin
    case (op.b_src)
      SRC_ELEM:  b_ext = {{(BW - EW){elem_b[EW-1]}}, elem_b};
      SRC_MINOR: b_ext = {{(BW - MW){minor_rd[MW-1]}}, minor_rd};
      default:   b_ext = {{(BW - AW){adj_rd[AW-1]}}, adj_rd};
    endcase
  end

  // Digit of the wide operand; only the top digit is signed
  always_comb begin
    case (cmd.digit)
      2'd0:    dig = {1'b0, b_ext[EW-1:0]};
      2'd1:    dig = {1'b0, b_ext[2*EW-1:EW]};
      2'd2:    dig = {1'b0, b_ext[3*EW-1:2*EW]};
      default: dig = {b_ext[BW-1], b_ext[BW-1:3*EW]};
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod       <= $signed(elem_a) * dig;
      prod_digit <= cmd.digit;
      prod_neg   <= op.neg;
    end
  end

  // Align partial product to its digit
  assign term_ext = {{(ACCW - PW){prod[PW-1]}}, prod};
  always_comb begin
    case (prod_digit)
      2'd0:    term_sh = term_ext;
      2'd1:    term_sh = term_ext << EW;
      2'd2:    term_sh = term_ext << (2 * EW);
      default: term_sh = term_ext << (3 * EW);
    endcase
  end

  // Accumulator and determinant
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= prod_neg ? acc - term_sh : acc + term_sh;
    end
    if (cmd.wr_en && cmd.phase == PH_DET) begin
      det <= acc;
    end
  end

  assign sing            = (det == '0);
  assign status.singular = sing;
  assign det_mag         = det[ACCW-1] ? ACCW'('0) - det : det;
  assign adj_mag         = adj_rd[AW-1] ? AW'('0) - adj_rd : adj_rd;

  // Restoring divider, one quotient bit per cycle
  assign ge = ({{(CW - NW){1'b0}}, rem} >= {{(CW - DW){1'b0}}, dreg});
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= {adj_mag[3*EW-1:0], {(2 * FRAC_BITS){1'b0}}};
      dreg <= {det_mag[ACCW-2:0], {EW{1'b0}}};
      q    <= '0;
      qneg <= adj_rd[AW-1] ^ det[ACCW-1];
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= NW'(rem - NW'(dreg));
      end
      dreg <= dreg >> 1;
      q    <= {q[QW-2:0], ge};
    end
  end

  // Saturate to the signed element range
  always_comb begin
    if (qneg) begin
      q_sat    = (q > HALF) ? HALF : q;
      quot_val = EW'(QW'(0) - q_sat);
    end else begin
      q_sat    = (q > HALF_M1) ? HALF_M1 : q;
      quot_val = EW'(q_sat);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_value <= sing ? elem_a : quot_val;
      result_index <= cmd.elem_idx;
      singular     <= sing;
      last_of_run  <= (cmd.elem_idx == LAST_IDX);
    end
  end

  // Divisor still holds the determinant at the final step
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (dreg != '0))
    else $error("divisor reached zero");

endmodule
